// ===== hw/rtl/che_pkg.sv =====
// ----------------------------------------------------------------------------
// che_pkg
// Shared constants for the canonical Huffman encoder: field widths, the
// transaction mode codes and the marker for an unused symbol.
// ----------------------------------------------------------------------------
package che_pkg;

   // field widths of the request and response transactions
   localparam int MODE_W     = 2;
   localparam int SYM_W      = 10;
   localparam int LEN_W      = 8;
   localparam int REQ_DATA_W = 24;
   localparam int WORD_BITS  = 32;

   // bit count of the accumulator and shift amounts up to the word size
   localparam int CNT_W = 5;
   localparam int SH_W  = 6;

   // stored length of a symbol that takes no part in the code
   localparam logic [LEN_W-1:0] LEN_UNUSED = 8'hff;

   // request modes carried in tuser
   localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BUILD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd3;

endpackage

// ===== hw/rtl/canonical_huffman_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_encoder_unit
// Canonical Huffman encoder: length table load, canonical code build and
// MSB-first packing of codes into 32-bit words.
// ----------------------------------------------------------------------------
// Load, encode and flush transactions are taken one per cycle while no build
// runs and the response register is free or being read; an encode or flush
// passes through the registered read of the length and code memories and then
// the accumulator update into the response register. A build holds off requests
// while it walks the length memory: a scan of 2^SYMBOL_BITS entries,
// MAX_CODE_LEN steps that turn the length histogram into start codes, and a
// second descending pass of 2^SYMBOL_BITS entries that writes the codes. When a
// sole symbol is found the start code steps and the second pass are replaced by
// a pass that zeroes every code. Both memories have undefined contents until
// written; build or encode only once every symbol has a length loaded.
// ----------------------------------------------------------------------------
module canonical_huffman_encoder_unit #(
   parameter int SYMBOL_BITS  = 10,
   parameter int MAX_CODE_LEN = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: symbol [9:0], code_length [17:10], zero [23:18]
   input  logic [che_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: mode [1:0]
   input  logic [che_pkg::MODE_W-1:0]         req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: packed_word [31:0]
   output logic [che_pkg::WORD_BITS-1:0]      rsp_tdata,
   // tlast: final_word
   output logic                               rsp_tlast
);

   import che_pkg::*;

   localparam int NUM_SYMS = 1 << SYMBOL_BITS;
   localparam int LI_W     = $clog2(MAX_CODE_LEN + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_BASE   = 3'd2;
   localparam logic [2:0] ST_ASSIGN = 3'd3;
   localparam logic [2:0] ST_CLEAR  = 3'd4;

   localparam logic [LEN_W-1:0]   MAX_LEN  = LEN_W'(MAX_CODE_LEN);
   localparam logic [LI_W-1:0]    TOP_LEN  = LI_W'(MAX_CODE_LEN);
   localparam logic [SYMBOL_BITS:0] LAST_SYM = (SYMBOL_BITS + 1)'(NUM_SYMS - 1);

   // request fields
   logic [SYM_W-1:0]       req_symbol;
   logic [LEN_W-1:0]       req_code_length;
   logic [MODE_W-1:0]      req_mode;
   logic                   req_fire;
   logic                   req_sym_ok;
   logic [SYMBOL_BITS-1:0] req_addr;
   logic [LEN_W-1:0]       load_len;

   // build sequencer
   logic [2:0]             state_ff, state_in;
   logic [SYMBOL_BITS:0]   idx_ff, idx_in;
   logic                   pend_ff, pend_in;
   logic [SYMBOL_BITS-1:0] pend_sym_ff, pend_sym_in;
   logic                   sole_seen_ff, sole_seen_in;
   logic                   sole_ff, sole_in;
   logic [LI_W-1:0]        len_idx_ff, len_idx_in;
   logic [WORD_BITS-1:0]   run_ff, run_in;
   logic [SYMBOL_BITS:0]   count_ff [MAX_CODE_LEN+1];
   logic [SYMBOL_BITS:0]   count_in [MAX_CODE_LEN+1];
   logic [WORD_BITS-1:0]   next_ff [MAX_CODE_LEN+1];
   logic [WORD_BITS-1:0]   next_in [MAX_CODE_LEN+1];

   // memory ports
   logic                    len_wr_en;
   logic                    len_rd_en;
   logic [SYMBOL_BITS-1:0]  len_rd_addr;
   logic [LEN_W-1:0]        len_rd;
   logic                    code_wr_en;
   logic [SYMBOL_BITS-1:0]  code_wr_addr;
   logic [MAX_CODE_LEN-1:0] code_wr_data;
   logic                    code_rd_en;
   logic [MAX_CODE_LEN-1:0] code_rd;

   // read data checks shared by the build and encode paths
   logic                    rd_len_ok;
   logic [LI_W-1:0]         rd_li;
   logic [SH_W-1:0]         rd_shamt;

   // encode stage
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_flush_ff, s2_flush_in;
   logic                    s2_sym_ok_ff, s2_sym_ok_in;
   logic                    s2_fire;
   logic                    out_free;
   logic                    enc_ok;
   logic [CNT_W-1:0]        enc_len;
   logic [WORD_BITS-1:0]    enc_aligned;
   logic [WORD_BITS-1:0]    enc_or;
   logic [SH_W-1:0]         enc_sum;
   logic [WORD_BITS-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]        bit_count_ff, bit_count_in;
   logic                    emit;
   logic [WORD_BITS-1:0]    emit_word;
   logic                    emit_last;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]    rsp_word_ff, rsp_word_in;
   logic                    rsp_last_ff, rsp_last_in;

   // request unpacking
   assign req_symbol      = req_tdata[SYM_W-1:0];
   assign req_code_length = req_tdata[SYM_W+LEN_W-1:SYM_W];
   assign req_mode        = req_tuser;
   assign req_sym_ok      = (req_symbol >> SYMBOL_BITS) == '0;
   assign req_addr        = SYMBOL_BITS'(req_symbol);
   assign load_len        = (req_code_length > MAX_LEN) ? LEN_UNUSED : req_code_length;

   // handshake: stage two must be free or moving on, no build running
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_fire    = s2_valid_ff && out_free;
   assign req_tready = (state_ff == ST_IDLE) && (!s2_valid_ff || s2_fire);
   assign req_fire   = req_tvalid && req_tready;

   // length memory
   assign len_wr_en   = req_fire && (req_mode == MODE_LOAD) && req_sym_ok;
   assign len_rd_en   = (req_fire && (req_mode == MODE_ENCODE))
                      || (((state_ff == ST_SCAN) || (state_ff == ST_ASSIGN))
                          && !idx_ff[SYMBOL_BITS]);
   assign len_rd_addr = (state_ff == ST_IDLE) ? req_addr : idx_ff[SYMBOL_BITS-1:0];

   che_ram #(
      .WIDTH (LEN_W),
      .DEPTH (NUM_SYMS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_wr_en),
      .wr_addr (req_addr),
      .wr_data (load_len),
      .rd_en   (len_rd_en),
      .rd_addr (len_rd_addr),
      .rd_data (len_rd)
   );

   // code memory
   assign code_rd_en = req_fire && (req_mode == MODE_ENCODE);

   che_ram #(
      .WIDTH (MAX_CODE_LEN),
      .DEPTH (NUM_SYMS)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (code_wr_en),
      .wr_addr (code_wr_addr),
      .wr_data (code_wr_data),
      .rd_en   (code_rd_en),
      .rd_addr (req_addr),
      .rd_data (code_rd)
   );

   // length read back from memory, as a code length index
   assign rd_len_ok = (len_rd != '0) && (len_rd <= MAX_LEN);
   assign rd_li     = LI_W'(len_rd);
   assign rd_shamt  = SH_W'(WORD_BITS) - SH_W'(rd_li);

   // build sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      pend_sym_in  = idx_ff[SYMBOL_BITS-1:0];
      sole_seen_in = sole_seen_ff;
      sole_in      = sole_ff;
      len_idx_in   = len_idx_ff;
      run_in       = run_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      code_wr_en   = 1'b0;
      code_wr_addr = pend_sym_ff;
      code_wr_data = MAX_CODE_LEN'(next_ff[rd_li] >> rd_shamt);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_mode == MODE_BUILD)) begin
               state_in     = ST_SCAN;
               idx_in       = '0;
               sole_seen_in = 1'b0;
               for (int k = 0; k <= MAX_CODE_LEN; k++) begin
                  count_in[k] = '0;
               end
            end
         end
         ST_SCAN: begin
            // issue one read a cycle, histogram each length in the cycle after its read
            if (!idx_ff[SYMBOL_BITS]) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + (SYMBOL_BITS + 1)'(1);
            end
            if (pend_ff) begin
               if (len_rd == '0) begin
                  sole_seen_in = 1'b1;
               end
               if (rd_len_ok) begin
                  count_in[rd_li] = count_ff[rd_li] + (SYMBOL_BITS + 1)'(1);
               end
            end
            if (idx_ff[SYMBOL_BITS] && !pend_ff) begin
               if (sole_seen_ff) begin
                  state_in = ST_CLEAR;
                  idx_in   = '0;
               end else begin
                  state_in   = ST_BASE;
                  len_idx_in = TOP_LEN;
                  run_in     = '0;
               end
            end
         end
         ST_BASE: begin
            // start code of each length, longest first
            next_in[len_idx_ff] = run_ff;
            run_in = run_ff + (WORD_BITS'(count_ff[len_idx_ff])
                               << (SH_W'(WORD_BITS) - SH_W'(len_idx_ff)));
            len_idx_in = len_idx_ff - LI_W'(1);
            if (len_idx_ff == LI_W'(1)) begin
               state_in = ST_ASSIGN;
               idx_in   = LAST_SYM;
            end
         end
         ST_ASSIGN: begin
            // descending symbol walk, each length hands out its next code
            if (!idx_ff[SYMBOL_BITS]) begin
               pend_in = 1'b1;
               idx_in  = idx_ff - (SYMBOL_BITS + 1)'(1);
            end
            if (pend_ff && rd_len_ok) begin
               code_wr_en     = 1'b1;
               next_in[rd_li] = next_ff[rd_li] + (WORD_BITS'(1) << rd_shamt);
            end
            if (idx_ff[SYMBOL_BITS] && !pend_ff) begin
               state_in = ST_IDLE;
               sole_in  = 1'b0;
            end
         end
         ST_CLEAR: begin
            // sole symbol: every code reads as zero
            code_wr_en   = 1'b1;
            code_wr_addr = idx_ff[SYMBOL_BITS-1:0];
            code_wr_data = '0;
            idx_in       = idx_ff + (SYMBOL_BITS + 1)'(1);
            if (idx_ff == LAST_SYM) begin
               state_in = ST_IDLE;
               sole_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // encode and flush stage
   assign enc_ok      = s2_sym_ok_ff && !sole_ff && rd_len_ok;
   assign enc_len     = CNT_W'(len_rd);
   assign enc_aligned = ((WORD_BITS'(code_rd) & ~({WORD_BITS{1'b1}} << enc_len))
                         << rd_shamt);
   assign enc_or      = acc_ff | (enc_aligned >> bit_count_ff);
   assign enc_sum     = SH_W'(bit_count_ff) + SH_W'(enc_len);

   always_comb begin
      acc_in       = acc_ff;
      bit_count_in = bit_count_ff;
      emit         = 1'b0;
      emit_word    = acc_ff;
      emit_last    = 1'b0;
      if (s2_fire) begin
         if (s2_flush_ff) begin
            if (bit_count_ff != '0) begin
               emit      = 1'b1;
               emit_last = 1'b1;
            end
            acc_in       = '0;
            bit_count_in = '0;
         end else if (enc_ok) begin
            bit_count_in = enc_sum[CNT_W-1:0];
            if (enc_sum[CNT_W]) begin
               // word full: emit it, keep the bits of the code that overflowed
               emit      = 1'b1;
               emit_word = enc_or;
               acc_in    = enc_aligned << (enc_len - enc_sum[CNT_W-1:0]);
            end else begin
               acc_in = enc_or;
            end
         end
      end
   end

   // stage two capture
   always_comb begin
      s2_valid_in  = s2_valid_ff && !s2_fire;
      s2_flush_in  = s2_flush_ff;
      s2_sym_ok_in = s2_sym_ok_ff;
      if (req_fire && ((req_mode == MODE_ENCODE) || (req_mode == MODE_FLUSH))) begin
         s2_valid_in  = 1'b1;
         s2_flush_in  = (req_mode == MODE_FLUSH);
         s2_sym_ok_in = req_sym_ok;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = emit_word;
         rsp_last_in  = emit_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         sole_ff      <= 1'b0;
         acc_ff       <= '0;
         bit_count_ff <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         sole_ff      <= sole_in;
         acc_ff       <= acc_in;
         bit_count_ff <= bit_count_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pend_sym_ff  <= pend_sym_in;
      sole_seen_ff <= sole_seen_in;
      len_idx_ff   <= len_idx_in;
      run_ff       <= run_in;
      count_ff     <= count_in;
      next_ff      <= next_in;
      s2_flush_ff  <= s2_flush_in;
      s2_sym_ok_ff <= s2_sym_ok_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_build_blocks_requests : assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request taken while a build is running");

   a_flush_clears_count : assert property (@(posedge clock) disable iff (reset)
      (s2_fire && s2_flush_ff) |=> (bit_count_ff == '0))
      else $error("bit count not cleared after a flush");

   a_sole_holds_accumulator : assert property (@(posedge clock) disable iff (reset)
      (sole_ff && s2_fire && !s2_flush_ff) |=> ($stable(bit_count_ff) && $stable(acc_ff)))
      else $error("accumulator changed while a sole symbol is set");

   a_build_starts_clean : assert property (@(posedge clock) disable iff (reset)
      ($rose(state_ff == ST_SCAN)) |-> (!s2_valid_ff && !pend_ff))
      else $error("build started with an encode still in flight");

endmodule

// ===== hw/rtl/che_ram.sv =====
// ----------------------------------------------------------------------------
// che_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
module che_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/canonical_huffman_encoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_encoder_unit_tb
// Self-checking bench for the canonical Huffman encoder. Length tables are
// loaded and codes built, then symbol streams are encoded and flushed. A
// behavioural copy of the tables and the bit accumulator predicts every packed
// word, and each response transaction is compared against it in order. Both
// channels idle at random, apart from one stretch with no idling at all.
// ----------------------------------------------------------------------------
module canonical_huffman_encoder_unit_tb;
   import che_pkg::*;

   localparam int MAX_LEN     = 24;
   localparam int NUM_SYMBOLS = 1 << SYM_W;
   localparam int IDLE_PCT    = 22;
   localparam int ITEM_TARGET = 1850;

   typedef enum {PH_COMPLETE, PH_OVERFULL, PH_UNDERFULL, PH_SOLE} phase_kind_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic                 last_word;
   } huff_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [WORD_BITS-1:0]  rsp_tdata;
   logic                  rsp_tlast;

   // mirror of the block state
   logic [LEN_W-1:0]      len_mirror  [NUM_SYMBOLS];
   logic [MAX_LEN-1:0]    code_mirror [NUM_SYMBOLS];
   logic                  sole_mirror = 1'b0;
   logic [WORD_BITS-1:0]  acc_mirror  = '0;
   int unsigned           fill_mirror = 0;

   huff_word_type         pending_words[$];
   int                    idle_pct      = IDLE_PCT;
   int                    items_sent    = 0;
   int                    builds_sent   = 0;
   int                    words_checked = 0;
   int                    flushed_words = 0;
   int                    error_count   = 0;

   canonical_huffman_encoder_unit #(
      .SYMBOL_BITS  (SYM_W),
      .MAX_CODE_LEN (MAX_LEN)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // canonical code assignment, longest length and highest symbol first
   function automatic void build_code_mirror();
      logic [WORD_BITS-1:0] run;
      logic [WORD_BITS-1:0] shifted;
      sole_mirror = 1'b0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
         if (len_mirror[s] == '0) sole_mirror = 1'b1;
      end
      if (sole_mirror) begin
         for (int s = 0; s < NUM_SYMBOLS; s++) code_mirror[s] = '0;
         return;
      end
      run = '0;
      for (int l = MAX_LEN; l >= 1; l--) begin
         for (int s = NUM_SYMBOLS - 1; s >= 0; s--) begin
            if (len_mirror[s] == l) begin
               shifted        = run >> (WORD_BITS - l);
               code_mirror[s] = shifted[MAX_LEN-1:0];
               run            = run + (32'd1 << (WORD_BITS - l));
            end
         end
      end
   endfunction

   // apply one accepted transaction to the mirror and queue any word it emits
   function automatic void predict_packed_words(input logic [MODE_W-1:0] mode,
                                                input logic [SYM_W-1:0]  sym,
                                                input logic [LEN_W-1:0]  clen);
      logic [WORD_BITS-1:0] aligned;
      int unsigned          l;
      case (mode)
         MODE_LOAD: begin
            len_mirror[sym] = (clen > MAX_LEN) ? LEN_UNUSED : clen;
         end
         MODE_BUILD: begin
            build_code_mirror();
            builds_sent++;
         end
         MODE_ENCODE: begin
            l = len_mirror[sym];
            if (!sole_mirror && l != 0 && l <= MAX_LEN) begin
               aligned = ({{(WORD_BITS - MAX_LEN){1'b0}}, code_mirror[sym]}
                          & ((32'd1 << l) - 32'd1)) << (WORD_BITS - l);
               acc_mirror  = acc_mirror | (aligned >> fill_mirror);
               fill_mirror = fill_mirror + l;
               if (fill_mirror >= WORD_BITS) begin
                  pending_words.push_back('{acc_mirror, 1'b0});
                  fill_mirror = fill_mirror - WORD_BITS;
                  acc_mirror  = aligned << (l - fill_mirror);
               end
            end
         end
         MODE_FLUSH: begin
            if (fill_mirror != 0) pending_words.push_back('{acc_mirror, 1'b1});
            acc_mirror  = '0;
            fill_mirror = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch on %s: expected %h, got %h at %0t", what, want, got, $time);
   endfunction

   // present one request transaction and wait for it to be taken
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                               input logic [LEN_W-1:0] clen);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W - SYM_W - LEN_W){1'b0}}, clen, sym};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_packed_words(mode, sym, clen);
      items_sent++;
   endtask

   task automatic send_noise(input logic [MODE_W-1:0] mode);
      send_request(mode, SYM_W'($urandom), LEN_W'($urandom));
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // compare each response transaction with the oldest predicted word
   always @(posedge clock) begin
      huff_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            note_mismatch("word with nothing pending", '0, rsp_tdata);
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata !== want.word) note_mismatch("packed_word", want.word, rsp_tdata);
            if (rsp_tlast !== want.last_word)
               note_mismatch("final_word", 32'(want.last_word), 32'(rsp_tlast));
            words_checked++;
            if (want.last_word) flushed_words++;
         end
      end
   end

   // flush with an empty accumulator right after reset
   task automatic test_empty_flush();
      send_noise(MODE_FLUSH);
      send_noise(MODE_FLUSH);
   endtask

   // fill the whole length table with a sole symbol, build, try to encode
   task automatic test_sole_symbol_table();
      logic [LEN_W-1:0] clen;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
         if (s == 0) clen = '0;
         else if ($urandom_range(7) == 0) clen = LEN_W'($urandom_range(254, MAX_LEN + 1));
         else clen = LEN_UNUSED;
         send_request(MODE_LOAD, SYM_W'(s), clen);
      end
      send_noise(MODE_BUILD);
      send_request(MODE_ENCODE, '0, '0);
      send_request(MODE_ENCODE, '1, '1);
      send_noise(MODE_FLUSH);
   endtask

   // complete code with lengths 1 to 24, word boundaries, stale and unused entries
   task automatic test_directed_code();
      send_request(MODE_LOAD, SYM_W'(0), LEN_W'(1));
      send_request(MODE_LOAD, SYM_W'(NUM_SYMBOLS - 1), LEN_W'(2));
      send_request(MODE_LOAD, SYM_W'(5), LEN_W'(3));
      for (int k = 4; k < MAX_LEN; k++) send_request(MODE_LOAD, SYM_W'(6 + k), LEN_W'(k));
      send_request(MODE_LOAD, SYM_W'(30), LEN_W'(MAX_LEN));
      send_request(MODE_LOAD, SYM_W'(31), LEN_W'(MAX_LEN));
      send_noise(MODE_BUILD);
      // 24 + 8 bits fill one word exactly
      send_request(MODE_ENCODE, SYM_W'(30), '0);
      send_request(MODE_ENCODE, SYM_W'(14), '0);
      send_request(MODE_ENCODE, SYM_W'(0), '0);
      send_request(MODE_ENCODE, SYM_W'(NUM_SYMBOLS - 1), '0);
      send_request(MODE_ENCODE, SYM_W'(5), '0);
      send_request(MODE_ENCODE, SYM_W'(31), '0);
      send_request(MODE_ENCODE, SYM_W'(16), '0);
      send_request(MODE_ENCODE, SYM_W'(500), '0);
      // length changed after the build uses the old code
      send_request(MODE_LOAD, SYM_W'(5), LEN_W'(7));
      send_request(MODE_ENCODE, SYM_W'(5), '0);
      // zero length without the sole flag, and an oversize length
      send_request(MODE_LOAD, SYM_W'(600), '0);
      send_request(MODE_ENCODE, SYM_W'(600), '0);
      send_request(MODE_LOAD, SYM_W'(601), LEN_W'(200));
      send_request(MODE_ENCODE, SYM_W'(601), '0);
      send_noise(MODE_FLUSH);
      send_noise(MODE_FLUSH);
      // a build leaves pending bits alone, here it also finds a sole symbol
      send_request(MODE_ENCODE, SYM_W'(NUM_SYMBOLS - 1), '0);
      send_request(MODE_ENCODE, SYM_W'(0), '0);
      send_noise(MODE_BUILD);
      send_request(MODE_ENCODE, SYM_W'(NUM_SYMBOLS - 1), '0);
      send_noise(MODE_FLUSH);
   endtask

   // new alphabet, build, then a stream of encodes with some noise
   task automatic run_phase(input phase_kind_type kind);
      int unsigned      leaf_len[$];
      logic [SYM_W-1:0] phase_syms[$];
      bit               taken[NUM_SYMBOLS];
      int unsigned      idx;
      int unsigned      n_leaves;
      int unsigned      n_ops;
      int unsigned      pick;
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] clen;
      // grow a complete prefix code by splitting leaves
      n_leaves = $urandom_range(2, 40);
      leaf_len = '{1, 1};
      while (leaf_len.size() < n_leaves) begin
         idx = $urandom_range(leaf_len.size() - 1);
         if (leaf_len[idx] < MAX_LEN) begin
            leaf_len[idx]++;
            leaf_len.push_back(leaf_len[idx]);
         end
      end
      case (kind)
         PH_OVERFULL: begin
            repeat ($urandom_range(1, 4)) leaf_len.push_back($urandom_range(1, MAX_LEN));
         end
         PH_UNDERFULL: leaf_len.delete($urandom_range(leaf_len.size() - 1));
         PH_SOLE:      leaf_len[$urandom_range(leaf_len.size() - 1)] = 0;
         default: ;
      endcase
      if ($urandom_range(9) == 0) leaf_len.push_back($urandom_range(254, MAX_LEN + 1));
      foreach (leaf_len[i]) begin
         do sym = SYM_W'($urandom_range(NUM_SYMBOLS - 1)); while (taken[sym]);
         taken[sym] = 1'b1;
         phase_syms.push_back(sym);
      end
      // retire the previous alphabet, then load the new one
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
         if (len_mirror[s] != LEN_UNUSED && !taken[s])
            send_request(MODE_LOAD, SYM_W'(s), LEN_UNUSED);
      end
      foreach (phase_syms[i]) send_request(MODE_LOAD, phase_syms[i], LEN_W'(leaf_len[i]));
      send_noise(MODE_BUILD);
      // symbol stream
      n_ops = (kind == PH_SOLE) ? $urandom_range(4, 12) : $urandom_range(40, 110);
      repeat (n_ops) begin
         pick = $urandom_range(99);
         sym  = phase_syms[$urandom_range(phase_syms.size() - 1)];
         if (pick < 82) begin
            send_request(MODE_ENCODE, sym, LEN_W'($urandom));
         end else if (pick < 87) begin
            send_noise(MODE_ENCODE);
         end else if (pick < 91) begin
            case ($urandom_range(3))
               0:       clen = '0;
               1:       clen = LEN_W'($urandom);
               default: clen = LEN_W'($urandom_range(1, MAX_LEN));
            endcase
            send_request(MODE_LOAD, sym, clen);
         end else begin
            send_noise(MODE_FLUSH);
         end
      end
      if ($urandom_range(1)) send_noise(MODE_FLUSH);
   endtask

   task automatic test_overfull_code();
      run_phase(PH_OVERFULL);
   endtask

   // random alphabets, with a stretch of phases where neither side idles
   task automatic test_random_streams();
      int             phase_no;
      int unsigned    r;
      phase_kind_type kind;
      run_phase(PH_SOLE);
      phase_no = 0;
      while (items_sent < ITEM_TARGET || phase_no < 4) begin
         idle_pct = (phase_no == 1 || phase_no == 2) ? 0 : IDLE_PCT;
         r    = $urandom_range(9);
         kind = (r < 7) ? PH_COMPLETE : (r < 8) ? PH_OVERFULL :
                (r < 9) ? PH_UNDERFULL : PH_SOLE;
         run_phase(kind);
         phase_no++;
      end
      idle_pct = IDLE_PCT;
   endtask

   // main sequence
   initial begin
      int guard;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_flush();
      test_sole_symbol_table();
      test_directed_code();
      test_overfull_code();
      test_random_streams();
      req_tvalid <= 1'b0;
      // drain outstanding words
      guard = 0;
      while (pending_words.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (16) @(posedge clock);
      if (pending_words.size() != 0) begin
         error_count++;
         $display("%0d predicted words never arrived", pending_words.size());
      end
      $display("covered %0d request transactions over %0d code builds", items_sent,
               builds_sent);
      $display("checked %0d packed words, %0d of them flushed partial words",
               words_checked, flushed_words);
      if (error_count == 0) begin
         $display("PASS canonical_huffman_encoder_unit");
      end else begin
         $display("FAIL canonical_huffman_encoder_unit");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAIL canonical_huffman_encoder_unit");
      $finish;
   end

endmodule
